/* rtl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and helpers for the quaternion to euler converter
// CORDIC stage record, pipeline record, angle constants and rounding.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // cordic datapath and angle widths
  localparam int DW = 36;
  localparam int ZW = 28;

  // pole classes carried on tuser
  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  // pi/2 in q.24, 1/K in q.30, pi/2 in q3.13
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [16:0] PITCH_POLE_Q13 = 17'd12868;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] ww;
    logic signed [31:0] xy;
    logic signed [31:0] zw;
    logic signed [31:0] yw;
    logic signed [31:0] xz;
    logic signed [31:0] xw;
    logic signed [31:0] yz;
    logic signed [34:0] norm;
    logic signed [33:0] test;
    logic [1:0]         pole;
    cordic_t            cr;
    cordic_t            cy;
    cordic_t            cp;
    logic signed [DW-1:0] t2;
    logic [47:0]        plo;
    logic [47:0]        phi;
    logic [16:0]        o_roll;
    logic [16:0]        o_pitch;
    logic [16:0]        o_yaw;
  } pipe_t;

  // atan(2^-i) in q.24
  function automatic logic signed [ZW-1:0] stage_angle(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = 28'sd13176795;
      1: a = 28'sd7778716;
      2: a = 28'sd4110060;
      3: a = 28'sd2086331;
      4: a = 28'sd1047214;
      5: a = 28'sd524117;
      6: a = 28'sd262123;
      7: a = 28'sd131069;
      default: begin
        if (i <= 24) a = ZW'(1) <<< (24 - i);
        else a = '0;
      end
    endcase
    return a;
  endfunction

  // turn the vector into the right half plane
  function automatic cordic_t cordic_pre(input logic signed [DW-1:0] x,
                                         input logic signed [DW-1:0] y);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    r.x = x;
    r.y = y;
    r.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = HALF_PI_Q24;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -HALF_PI_Q24;
      end
    end
    return r;
  endfunction

  // one vectoring micro-rotation
  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t r;
    r = c;
    if (c.y > 0) begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + stage_angle(i);
    end else begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - stage_angle(i);
    end
    return r;
  endfunction

  // q.24 to q3.13 with round half up
  function automatic logic [16:0] to_q13(input logic signed [29:0] a);
    logic signed [30:0] s;
    s = 31'(a) + 31'sd1024;
    return s[27:11];
  endfunction

endpackage

/* rtl/quaternion_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to roll, pitch, yaw converter
// Throughput: one beat per cycle unless m_tready stalls it; set by the unrolled roll/yaw and pitch CORDICs.
// Pitch CORDIC runs after the yaw magnitude, so the two chains are in series.
// Reset clears the stage valid bits only; no state is kept between beats.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // quat_x, quat_y, quat_z, quat_w, then zero fill
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // roll_angle, pitch_angle, yaw_angle, then zero fill
  output logic [55:0] m_tdata,
  // pole_case
  output logic [1:0]  m_tuser
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int N      = CORDIC_STAGES;
  localparam int ST_CR  = 5;
  localparam int ST_M1  = ST_CR + N;
  localparam int ST_M2  = ST_M1 + 1;
  localparam int ST_PP  = ST_M2 + 1;
  localparam int ST_CP  = ST_PP + 1;
  localparam int ST_OUT = ST_CP + N;
  localparam int NS     = ST_OUT + 1;
  localparam int DW     = q2e_pkg::DW;

  q2e_pkg::pipe_t p [NS];
  logic [NS-1:0]  v;
  logic [NS:0]    rdy;
  logic signed [15:0] ext [4];

  // component sign handling to 16 bits
  for (genvar j = 0; j < 4; j++) begin : g_ext
    if (CW >= 16) begin : g_wide
      assign ext[j] = s_tdata[j*CW + CW - 1 -: 16];
    end else begin : g_narrow
      assign ext[j] = 16'(signed'(s_tdata[j*CW +: CW]));
    end
  end

  // per-stage ready chain
  assign rdy[NS] = m_tready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign s_tready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    // index of the stage feeding this one
    localparam int KP = (k == 0) ? 0 : k - 1;
    q2e_pkg::pipe_t d;

    always_comb begin
      logic signed [47:0] t1000;
      logic signed [47:0] n499;
      logic [65:0]        prod;
      logic signed [29:0] roll_a;
      t1000  = '0;
      n499   = '0;
      prod   = '0;
      roll_a = '0;
      if (k == 0) begin
        d    = '0;
        d.qx = ext[0];
        d.qy = ext[1];
        d.qz = ext[2];
        d.qw = ext[3];
      end else begin
        d = p[KP];
        if (k == 1) begin
          // all pair products
          d.xx = p[KP].qx * p[KP].qx;
          d.yy = p[KP].qy * p[KP].qy;
          d.zz = p[KP].qz * p[KP].qz;
          d.ww = p[KP].qw * p[KP].qw;
          d.xy = p[KP].qx * p[KP].qy;
          d.zw = p[KP].qz * p[KP].qw;
          d.yw = p[KP].qy * p[KP].qw;
          d.xz = p[KP].qx * p[KP].qz;
          d.xw = p[KP].qx * p[KP].qw;
          d.yz = p[KP].qy * p[KP].qz;
        end else if (k == 2) begin
          // norm, test term and cordic operands
          d.norm = 35'(p[KP].xx) + 35'(p[KP].yy) + 35'(p[KP].zz) + 35'(p[KP].ww);
          d.test = 34'(p[KP].xy) + 34'(p[KP].zw);
          d.cr.y = (DW'(p[KP].yw) - DW'(p[KP].xz)) <<< 1;
          d.cr.x = DW'(p[KP].xx) - DW'(p[KP].yy) - DW'(p[KP].zz) + DW'(p[KP].ww);
          d.cy.y = (DW'(p[KP].xw) - DW'(p[KP].yz)) <<< 1;
          d.cy.x = DW'(p[KP].yy) - DW'(p[KP].xx) - DW'(p[KP].zz) + DW'(p[KP].ww);
        end else if (k == 3) begin
          // pole test against 0.499 of the norm
          t1000 = 48'(p[KP].test) * 48'sd1000;
          n499  = 48'(p[KP].norm) * 48'sd499;
          d.t2  = DW'(p[KP].test) <<< 1;
          if (t1000 > n499) begin
            d.pole = q2e_pkg::POLE_NORTH;
          end else if (t1000 < -n499) begin
            d.pole = q2e_pkg::POLE_SOUTH;
          end else begin
            d.pole = q2e_pkg::POLE_NONE;
          end
          if (d.pole != q2e_pkg::POLE_NONE) begin
            d.cr.x = DW'(p[KP].qw);
            d.cr.y = DW'(p[KP].qx);
          end
        end else if (k == 4) begin
          d.cr = q2e_pkg::cordic_pre(p[KP].cr.x, p[KP].cr.y);
          d.cy = q2e_pkg::cordic_pre(p[KP].cy.x, p[KP].cy.y);
        end else if (k >= ST_CR && k < ST_M1) begin
          // roll and yaw micro-rotations
          d.cr = q2e_pkg::cordic_step(p[KP].cr, k - ST_CR);
          d.cy = q2e_pkg::cordic_step(p[KP].cy, k - ST_CR);
        end else if (k == ST_M1) begin
          // yaw magnitude times 1/K, two partial products
          d.plo = 48'(p[KP].cy.x[17:0]) * 48'(q2e_pkg::INV_GAIN_Q30);
          d.phi = 48'(p[KP].cy.x[DW-1:18]) * 48'(q2e_pkg::INV_GAIN_Q30);
        end else if (k == ST_M2) begin
          prod   = (66'(p[KP].phi) << 18) + 66'(p[KP].plo);
          d.cp.x = DW'(prod >> 30);
          d.cp.y = p[KP].t2;
        end else if (k == ST_PP) begin
          d.cp = q2e_pkg::cordic_pre(p[KP].cp.x, p[KP].cp.y);
        end else if (k >= ST_CP && k < ST_OUT) begin
          d.cp = q2e_pkg::cordic_step(p[KP].cp, k - ST_CP);
        end else begin
          // output rounding and pole selection
          roll_a = p[KP].cr.zero ? 30'sd0 : 30'(p[KP].cr.z);
          case (p[KP].pole)
            q2e_pkg::POLE_NORTH: begin
              d.o_roll  = q2e_pkg::to_q13(roll_a <<< 1);
              d.o_pitch = q2e_pkg::PITCH_POLE_Q13;
              d.o_yaw   = '0;
            end
            q2e_pkg::POLE_SOUTH: begin
              d.o_roll  = q2e_pkg::to_q13(-(roll_a <<< 1));
              d.o_pitch = -q2e_pkg::PITCH_POLE_Q13;
              d.o_yaw   = '0;
            end
            default: begin
              d.o_roll  = q2e_pkg::to_q13(roll_a);
              d.o_pitch = q2e_pkg::to_q13(p[KP].cp.zero ? 30'sd0 : 30'(p[KP].cp.z));
              d.o_yaw   = q2e_pkg::to_q13(p[KP].cy.zero ? 30'sd0 : 30'(p[KP].cy.z));
            end
          endcase
        end
      end
    end

    // stage register with its valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= (k == 0) ? s_tvalid : v[KP];
      end
      if (rdy[k]) begin
        p[k] <= d;
      end
    end
  end

  // output beat
  assign m_tvalid = v[NS-1];
  assign m_tdata  = {5'b0, p[NS-1].o_yaw, p[NS-1].o_pitch, p[NS-1].o_roll};
  assign m_tuser  = p[NS-1].pole;

  // pole class is one of three codes
  a_pole_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("invalid pole class");

  // yaw is zero at both poles
  a_pole_yaw: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != q2e_pkg::POLE_NONE) |-> (m_tdata[50:34] == 17'd0))
    else $error("yaw not zero at pole");

  // north pole pitch is +pi/2
  a_north_pitch: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == q2e_pkg::POLE_NORTH) |->
      (m_tdata[33:17] == q2e_pkg::PITCH_POLE_Q13))
    else $error("north pole pitch wrong");

endmodule

/* tb/quaternion_to_euler_angles_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb: self-checking bench for the euler converter
// Streams quaternions through the block with random stalls on both sides and
// compares roll, pitch, yaw and pole class against a bit-exact CORDIC model.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGE = 16;
  localparam longint HALF_PI = 26353589;
  localparam longint INV_K = 652032874;

  typedef struct packed {
    logic [16:0] roll;
    logic [16:0] pitch;
    logic [16:0] yaw;
    logic [1:0]  pole;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0] m_tuser;

  logic [63:0] quat_pending[$];
  euler_t angles_due[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_pole = 0;
  bit calm = 1'b0;
  bit hold = 1'b0;
  bit in_taken = 1'b0;

  quaternion_to_euler_angles uut (.*);

  initial forever #6 clk = ~clk;

  // floor shift
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint step_angle(int i);
    longint tab[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                       262123, 131069};
    if (i < 8) return tab[i];
    if (i <= 24) return longint'(1) << (24 - i);
    return 0;
  endfunction

  // vectoring atan2 in q.24, gained magnitude out
  function automatic longint vec_atan2(longint yi, longint xi, output longint mag);
    longint x, y, z, t, dx, dy;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin x = y; y = -t; z = HALF_PI; end
      else begin x = -y; y = t; z = -HALF_PI; end
    end
    for (int i = 0; i < NSTAGE; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (y > 0) begin x += dx; y -= dy; z += step_angle(i); end
      else begin x -= dx; y += dy; z -= step_angle(i); end
    end
    mag = x;
    return z;
  endfunction

  function automatic logic [16:0] q13(longint a);
    longint r;
    r = fshr(a + 1024, 11);
    return r[16:0];
  endfunction

  function automatic euler_t convert_quat(logic [63:0] d);
    longint x, y, z, w, xx, yy, zz, ww, nrm, tst, mag, hyp, a;
    euler_t e;
    x = longint'($signed(d[15:0]));  y = longint'($signed(d[31:16]));
    z = longint'($signed(d[47:32])); w = longint'($signed(d[63:48]));
    xx = x*x; yy = y*y; zz = z*z; ww = w*w;
    nrm = xx + yy + zz + ww;
    tst = x*y + z*w;
    if (tst * 1000 > 499 * nrm) begin
      a = vec_atan2(x, w, mag);
      e.roll = q13(2 * a); e.pitch = q13(HALF_PI + 1); e.yaw = '0;
      e.pole = q2e_pkg::POLE_NORTH;
    end else if (tst * 1000 < -(499 * nrm)) begin
      a = vec_atan2(x, w, mag);
      e.roll = q13(-2 * a); e.pitch = q13(-(HALF_PI + 1)); e.yaw = '0;
      e.pole = q2e_pkg::POLE_SOUTH;
    end else begin
      e.roll = q13(vec_atan2(2*(y*w - x*z), xx - yy - zz + ww, mag));
      e.yaw = q13(vec_atan2(2*(x*w - y*z), -xx + yy - zz + ww, mag));
      hyp = (mag * INV_K) >>> 30;
      e.pitch = q13(vec_atan2(2*tst, hyp, mag));
      e.pole = q2e_pkg::POLE_NONE;
    end
    return e;
  endfunction

  function automatic logic [63:0] pack_quat(int x, int y, int z, int w);
    return {w[15:0], z[15:0], y[15:0], x[15:0]};
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] exp);
    errors++;
    $display("mismatch beat %0d %s: got %0d expected %0d", n_recv, what,
             $signed(got), $signed(exp));
  endtask

  // driver: falling edge, random gaps, a waiting beat is held
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (!hold && quat_pending.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
          s_tvalid <= 1'b1;
          s_tdata <= quat_pending[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // predictor on accepted input beats
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      angles_due.push_back(convert_quat(s_tdata));
      quat_pending.pop_front();
      n_sent++;
    end
  end

  // monitor: sample on rising edge
  always @(posedge clk) begin
    euler_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (angles_due.size() == 0) begin
        errors++;
        $display("unexpected output beat %0d", n_recv);
      end else begin
        e = angles_due.pop_front();
        if (m_tdata[16:0] !== e.roll) report_mismatch("roll", m_tdata[16:0], e.roll);
        if (m_tdata[33:17] !== e.pitch) report_mismatch("pitch", m_tdata[33:17], e.pitch);
        if (m_tdata[50:34] !== e.yaw) report_mismatch("yaw", m_tdata[50:34], e.yaw);
        if (m_tuser !== e.pole) report_mismatch("pole", {15'd0, m_tuser}, {15'd0, e.pole});
        if (e.pole != q2e_pkg::POLE_NONE) n_pole++;
      end
      n_recv++;
    end
  end

  // stimulus
  initial begin
    int v;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: zero, extremes, both poles, axes
    quat_pending.push_back(pack_quat(0, 0, 0, 0));
    quat_pending.push_back(pack_quat(0, 0, 0, 32767));
    quat_pending.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_pending.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_pending.push_back(pack_quat(23170, 23170, 0, 0));
    quat_pending.push_back(pack_quat(23170, -23170, 0, 0));
    quat_pending.push_back(pack_quat(16384, 16384, 16384, 16384));
    quat_pending.push_back(pack_quat(16384, -16384, 16384, -16384));
    quat_pending.push_back(pack_quat(32767, 0, 0, 0));
    quat_pending.push_back(pack_quat(0, 32767, 0, 0));
    quat_pending.push_back(pack_quat(0, 0, 32767, 0));
    quat_pending.push_back(pack_quat(0, 0, 0, -32768));
    quat_pending.push_back(pack_quat(-32768, 0, 0, 32767));
    quat_pending.push_back(pack_quat(1, 1, 0, 0));
    quat_pending.push_back(pack_quat(1, -1, 0, 0));
    quat_pending.push_back(pack_quat(0, 0, 100, 100));
    quat_pending.push_back(pack_quat(-5, 7, -3, 2));
    wait (quat_pending.size() == 0);
    // pause until drained
    hold = 1'b1;
    wait (angles_due.size() == 0);
    repeat (50) @(posedge clk);
    @(negedge clk) hold = 1'b0;
    // random: mix of full range, near-pole and small magnitudes
    for (int k = 0; k < 500; k++) begin
      if (k == 200) calm = 1'b1;
      if (k == 300) calm = 1'b0;
      v = $urandom_range(3);
      if (v == 0) begin
        int a, b;
        a = $urandom_range(32767); b = $urandom_range(2000);
        if ($urandom_range(1)) quat_pending.push_back(pack_quat(a, a - 1000 + b,
            $urandom_range(4000) - 2000, $urandom_range(4000) - 2000));
        else quat_pending.push_back(pack_quat(a, -a + 1000 - b,
            $urandom_range(4000) - 2000, $urandom_range(4000) - 2000));
      end else if (v == 1) begin
        quat_pending.push_back(pack_quat($urandom_range(64) - 32, $urandom_range(64) - 32,
                                         $urandom_range(64) - 32, $urandom_range(64) - 32));
      end else begin
        quat_pending.push_back({$urandom, $urandom});
      end
      while (quat_pending.size() > 8) @(posedge clk);
    end
    wait (quat_pending.size() == 0 && !s_tvalid);
    wait (angles_due.size() == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d quaternions, checked %0d angle beats (%0d at a pole)",
             n_sent, n_recv, n_pole);
    if (errors == 0 && angles_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
